### rtl/sdl_pkg.sv
// package: sizes, codes and request/result types for the sorted descending list
`timescale 1ns / 1ps

package sdl_pkg;

    // list capacity, the count width that follows from it and the result count width
    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;

    // request mode codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // what every cell of the chain does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_OUT
    } cell_op_t;

    // control broadcast to the whole chain
    typedef struct packed {
        cell_op_t           op;
        logic signed [31:0] key;
    } cell_ctrl_t;

    // input request
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } sdl_in_t;

    // result
    typedef struct packed {
        logic [1:0]           status;
        logic                 found;
        logic signed [31:0]   head_value;
        logic                 is_empty;
        logic [COUNT_W-1:0]   count;
    } sdl_out_t;

endpackage

### rtl/sorted_descending_list.sv
// top level: chain of cells holding the list, count and result register
//
//  channel  | ports                    | payload
//  ---------+--------------------------+------------------------
//  request  | s_valid s_ready s_data   | sdl_in_t  (mode, value)
//  result   | m_valid m_ready m_data   | sdl_out_t (status, found, head_value, is_empty, count)
//
// one request per cycle while s_ready is high: all cells compare against the broadcast key
// at once and update on acceptance, when the result register is loaded as well
// reset clears the count and the result valid flag; the result payload and cell contents are not reset
// s_ready is high while the result register is empty or being taken
`timescale 1ns / 1ps

module sorted_descending_list (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sdl_pkg::sdl_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output sdl_pkg::sdl_out_t m_data
);

    logic [sdl_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      m_valid_reg;
    sdl_pkg::sdl_out_t         m_data_reg, m_data_next;
    sdl_pkg::cell_ctrl_t       ctrl;
    logic                      accept;
    logic                      is_full;
    logic                      is_zero;
    logic [1:0]                status;

    logic               occ   [sdl_pkg::DEPTH];
    logic               ge    [sdl_pkg::DEPTH];
    logic               hit   [sdl_pkg::DEPTH];
    logic               lge   [sdl_pkg::DEPTH];
    logic signed [31:0] val   [sdl_pkg::DEPTH];
    logic signed [31:0] lval  [sdl_pkg::DEPTH];
    logic signed [31:0] rval  [sdl_pkg::DEPTH];
    logic signed [31:0] vnext [sdl_pkg::DEPTH];
    logic [sdl_pkg::DEPTH-1:0] hit_vec;

    logic [sdl_pkg::CNT_W+sdl_pkg::COUNT_W-1:0] cnt_wide;

    // handshake
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign is_full = (cnt_reg == sdl_pkg::CNT_W'(sdl_pkg::DEPTH));
    assign is_zero = (cnt_reg == '0);

    // decode request into chain control and new count
    always_comb begin
        ctrl.key = s_data.value;
        ctrl.op  = sdl_pkg::CELL_HOLD;
        cnt_next = cnt_reg;
        status   = sdl_pkg::ST_OK;
        unique case (s_data.mode)
            sdl_pkg::MODE_INSERT: begin
                if (is_full) begin
                    status = sdl_pkg::ST_FULL;
                end else begin
                    if (accept) begin
                        ctrl.op = sdl_pkg::CELL_INSERT;
                    end
                    cnt_next = cnt_reg + sdl_pkg::CNT_W'(1);
                end
            end
            sdl_pkg::MODE_REMOVE: begin
                if (is_zero) begin
                    status = sdl_pkg::ST_EMPTY;
                end else begin
                    if (accept) begin
                        ctrl.op = sdl_pkg::CELL_SHIFT_OUT;
                    end
                    cnt_next = cnt_reg - sdl_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // neighbour wiring of the chain
    always_comb begin
        for (int i = 0; i < sdl_pkg::DEPTH; i++) begin
            occ[i] = (sdl_pkg::CNT_W'(i) < cnt_reg);
            if (i == 0) begin
                lge[i]  = 1'b1;
                lval[i] = ctrl.key;
            end else begin
                lge[i]  = ge[i-1];
                lval[i] = val[i-1];
            end
            if (i == sdl_pkg::DEPTH - 1) begin
                rval[i] = val[i];
            end else begin
                rval[i] = val[i+1];
            end
            hit_vec[i] = hit[i];
        end
    end

    // the cells
    for (genvar g = 0; g < sdl_pkg::DEPTH; g++) begin : g_cell
        sdl_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (occ[g]),
            .left_ge     (lge[g]),
            .left_value  (lval[g]),
            .right_value (rval[g]),
            .ge          (ge[g]),
            .hit         (hit[g]),
            .value       (val[g]),
            .value_next  (vnext[g])
        );
    end

    // result assembly from the post-operation state
    assign cnt_wide = {{sdl_pkg::COUNT_W{1'b0}}, cnt_next};

    always_comb begin
        m_data_next.status     = status;
        m_data_next.found      = (s_data.mode == sdl_pkg::MODE_SEARCH) && (|hit_vec);
        m_data_next.is_empty   = (cnt_next == '0);
        m_data_next.head_value = (cnt_next == '0) ? 32'sd0 : vnext[0];
        m_data_next.count      = cnt_wide[sdl_pkg::COUNT_W-1:0];
    end

    // count and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

### rtl/sdl_cell.sv
// one storage cell of the sorted chain: compare, keep, take key or shift
`timescale 1ns / 1ps

module sdl_cell (
    input  logic                aclk,
    input  sdl_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                left_ge,
    input  logic signed [31:0]  left_value,
    input  logic signed [31:0]  right_value,
    output logic                ge,
    output logic                hit,
    output logic signed [31:0]  value,
    output logic signed [31:0]  value_next
);

    logic signed [31:0] value_reg;

    // this cell stays ahead of an inserted key
    assign ge  = occupied && (value_reg >= ctrl.key);
    // search match
    assign hit = occupied && (value_reg == ctrl.key);
    assign value = value_reg;

    // next contents of the cell
    always_comb begin
        unique case (ctrl.op)
            sdl_pkg::CELL_INSERT: begin
                if (ge) begin
                    value_next = value_reg;
                end else if (left_ge) begin
                    value_next = ctrl.key;
                end else begin
                    value_next = left_value;
                end
            end
            sdl_pkg::CELL_SHIFT_OUT: value_next = right_value;
            default:                 value_next = value_reg;
        endcase
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

### tb/sv/tb_sorted_descending_list.sv
// testbench for the sorted descending list: random and directed requests checked against a list model
`timescale 1ns / 1ps

module tb_sorted_descending_list;

    // the one mode code that the package leaves unnamed
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

    localparam int RANDOM_REQS   = 1750;
    localparam int STALL_AT      = 500;
    localparam int STALL_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 10;

    // one queued request with the idle cycles before it and an optional drain wait
    typedef struct {
        sdl_pkg::sdl_in_t req;
        int               idle;
        bit               drain;
    } pending_req_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    sdl_pkg::sdl_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    sdl_pkg::sdl_out_t m_data;

    pending_req_t pending_reqs[$];
    sdl_pkg::sdl_out_t expected_results[$];
    logic signed [31:0] list_values[$];
    int failures = 0;
    bit stimulus_ready = 1'b0;

    sorted_descending_list u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    always #4 aclk = ~aclk;

    // apply one request to the list model and return the result it should give
    function automatic sdl_pkg::sdl_out_t apply_to_list(sdl_pkg::sdl_in_t req);
        sdl_pkg::sdl_out_t res;
        int pos;
        res = '0;
        res.status = sdl_pkg::ST_OK;
        case (req.mode)
            sdl_pkg::MODE_INSERT: begin
                if (list_values.size() >= sdl_pkg::DEPTH) begin
                    res.status = sdl_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < list_values.size() && list_values[pos] >= req.value)
                        pos++;
                    list_values.insert(pos, req.value);
                end
            end
            sdl_pkg::MODE_REMOVE: begin
                if (list_values.size() == 0)
                    res.status = sdl_pkg::ST_EMPTY;
                else
                    void'(list_values.pop_front());
            end
            sdl_pkg::MODE_SEARCH: begin
                foreach (list_values[i])
                    if (list_values[i] == req.value)
                        res.found = 1'b1;
            end
            default: begin
            end
        endcase
        res.head_value = (list_values.size() > 0) ? list_values[0] : '0;
        res.is_empty   = (list_values.size() == 0);
        res.count      = sdl_pkg::COUNT_W'(list_values.size());
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // values: a small pool for duplicates and search hits, the extremes, or anything
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $signed($urandom_range(0, 16)) - 8;
        if (r == 5) begin
            case ($urandom_range(0, 3))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_req(logic [1:0] mode, logic signed [31:0] value, int idle, bit drain);
        pending_req_t p;
        p.req.mode  = mode;
        p.req.value = value;
        p.idle      = idle;
        p.drain     = drain;
        pending_reqs.push_back(p);
    endtask

    // stimulus: directed corners, then phases that fill, drain or mix the list
    initial begin
        int phase_left;
        int ins_pct;
        int rem_pct;
        bit phase_idles;
        int r;
        logic [1:0] mode;

        phase_left  = 0;
        ins_pct     = 35;
        rem_pct     = 35;
        phase_idles = 1'b1;

        // empty list: remove, search and the unused mode
        queue_req(sdl_pkg::MODE_REMOVE, 32'sd0, 0, 1'b0);
        queue_req(sdl_pkg::MODE_SEARCH, 32'sd0, 0, 1'b0);
        queue_req(MODE_UNUSED, VAL_MAX, 0, 1'b0);
        // extremes and equal values
        queue_req(sdl_pkg::MODE_INSERT, VAL_MIN, 0, 1'b0);
        queue_req(sdl_pkg::MODE_INSERT, 32'sd0, 0, 1'b0);
        queue_req(sdl_pkg::MODE_INSERT, 32'sd0, 1, 1'b0);
        queue_req(sdl_pkg::MODE_INSERT, VAL_MAX, 0, 1'b0);
        queue_req(sdl_pkg::MODE_INSERT, -32'sd1, 0, 1'b0);
        queue_req(sdl_pkg::MODE_SEARCH, VAL_MIN, 0, 1'b0);
        queue_req(sdl_pkg::MODE_SEARCH, 32'sd5, 0, 1'b0);
        queue_req(MODE_UNUSED, VAL_MIN, 2, 1'b0);
        // fill to capacity, then one refused insert
        for (int i = 0; i < sdl_pkg::DEPTH - 5; i++)
            queue_req(sdl_pkg::MODE_INSERT, $signed($urandom_range(0, 6)) - 3, 0, 1'b0);
        queue_req(sdl_pkg::MODE_INSERT, VAL_MAX, 0, 1'b0);
        queue_req(sdl_pkg::MODE_REMOVE, 32'sd0, 0, 1'b0);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (phase_left == 0) begin
                phase_left  = $urandom_range(40, 120);
                phase_idles = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 2))
                    0: begin ins_pct = 70; rem_pct = 15; end
                    1: begin ins_pct = 15; rem_pct = 70; end
                    default: begin ins_pct = 35; rem_pct = 35; end
                endcase
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                mode = sdl_pkg::MODE_INSERT;
            else if (r < ins_pct + rem_pct)
                mode = sdl_pkg::MODE_REMOVE;
            else if (r < 97)
                mode = sdl_pkg::MODE_SEARCH;
            else
                mode = MODE_UNUSED;
            queue_req(mode, pick_value(), phase_idles ? pick_idle() : 0, (n % 400) == 0);
        end
        stimulus_ready = 1'b1;
    end

    // reset
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // request driver: valid holds until accepted, the next request is queued up behind it
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(apply_to_list(s_data));
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_reqs[0].idle > 0) begin
                    pending_reqs[0].idle--;
                    s_valid <= 1'b0;
                end else if (pending_reqs[0].drain && expected_results.size() != 0) begin
                    s_valid <= 1'b0;
                end else begin
                    s_data  <= pending_reqs[0].req;
                    s_valid <= 1'b1;
                    void'(pending_reqs.pop_front());
                end
            end
        end
    end

    // result receiver: random back-pressure, quiet stretches and one long hold-off
    always @(posedge aclk) begin
        static int cycle_cnt    = 0;
        static int taken        = 0;
        static int stall_left   = 0;
        static int idle_left    = 0;
        static bit stall_done   = 1'b0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            cycle_cnt++;
            if (m_valid && m_ready)
                taken++;
            if (taken == STALL_AT && !stall_done) begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ((cycle_cnt / 256) % 4 != 0)
                    idle_left = pick_idle();
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        sdl_pkg::sdl_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request waiting: %p", m_data);
                failures++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    failures++;
                end
                if (m_data.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, m_data.found);
                    failures++;
                end
                if (m_data.head_value !== want.head_value) begin
                    $error("head_value: expected %0d, actual %0d",
                           want.head_value, m_data.head_value);
                    failures++;
                end
                if (m_data.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, actual %0d", want.is_empty, m_data.is_empty);
                    failures++;
                end
                if (m_data.count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, m_data.count);
                    failures++;
                end
            end
        end
    end

    // end of run: all requests sent, all results back, then a short settle
    initial begin
        @(posedge aclk);
        while (!stimulus_ready || pending_reqs.size() != 0 || s_valid
               || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

endmodule

### files.f
rtl/sdl_pkg.sv
rtl/sdl_cell.sv
rtl/sorted_descending_list.sv
tb/sv/tb_sorted_descending_list.sv
